### rtl/fskm_pkg.sv
// ----------------------------------------------------------------------------
// fskm_pkg
// types, constants and the sine table builder for the fsk frame modulator
// ----------------------------------------------------------------------------
package fskm_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned SampleBits = 12;
  localparam int unsigned AddrBits   = $clog2(TableDepth);
  localparam int unsigned StepBits   = 16;
  localparam int unsigned LeftBits   = 4;

  // start, eight data, parity, stop
  localparam logic [LeftBits-1:0] FrameBits = 4'd11;
  localparam logic [LeftBits-1:0] LeftParity = 4'd2;
  localparam logic [LeftBits-1:0] LeftData   = 4'd3;

  localparam logic [StepBits-1:0] MarkStepRst  = 16'd1567;
  localparam logic [StepBits-1:0] SpaceStepRst = 16'd2872;
  localparam logic [StepBits-1:0] BitStepRst   = 16'd1567;

  // pi/2 in q2.62 and its per-entry step
  localparam logic [63:0] HalfPiQ62  = 64'h6487ED5110B4611A;
  localparam logic [63:0] HalfPiStep = HalfPiQ62 / TableDepth;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdLoad = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegMarkStep  = 2'd0,
    RegSpaceStep = 2'd1,
    RegBitStep   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  ready_res;
    logic                  line_bit;
  } out_word_t;

  typedef struct packed {
    logic [StepBits-1:0] mark_step;
    logic [StepBits-1:0] space_step;
    logic [StepBits-1:0] bit_step;
  } cfg_t;

  typedef logic [TableDepth-1:0][SampleBits-1:0] sine_rom_t;

  // (a * b) >> 62, product of two q2.62 values
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // taylor series sine on [0, pi/2], q62 in and out
  function automatic logic [63:0] sin_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q62(term, x2) / 64'd110; sum = sum - term;
    term = mul_q62(term, x2) / 64'd156; sum = sum + term;
    term = mul_q62(term, x2) / 64'd210; sum = sum - term;
    term = mul_q62(term, x2) / 64'd272; sum = sum + term;
    term = mul_q62(term, x2) / 64'd342; sum = sum - term;
    term = mul_q62(term, x2) / 64'd420; sum = sum + term;
    term = mul_q62(term, x2) / 64'd506; sum = sum - term;
    return sum;
  endfunction

  // offset sine table, evaluated at elaboration only
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [31:0] half;
    logic [31:0] top;
    logic [31:0] t;
    logic [31:0] quad;
    logic [31:0] r;
    logic [31:0] m;
    logic [31:0] mag;
    logic [31:0] fl;
    logic [31:0] v;
    logic [63:0] s;
    half = 32'd1 << (SampleBits - 1);
    top  = (32'd1 << SampleBits) - 32'd1;
    for (int i = 0; i < TableDepth; i++) begin
      t    = 32'(4 * i);
      quad = t / TableDepth;
      r    = t % TableDepth;
      m    = quad[0] ? 32'(TableDepth) - r : r;
      if (m == 32'd0 || m == 32'(TableDepth)) begin
        mag = (m == 32'd0) ? 32'd0 : half;
        v   = (quad < 32'd2) ? half + mag : half - mag;
      end else begin
        s  = sin_q62(HalfPiStep * {32'd0, m});
        fl = 32'(s >> (63 - SampleBits));
        if (quad < 32'd2) begin
          v = half + fl;
        end else begin
          v = (fl >= half) ? 32'd0 : half - fl - 32'd1;
        end
      end
      if (v > top) begin
        v = top;
      end
      rom[i] = v[SampleBits-1:0];
    end
    return rom;
  endfunction

endpackage

### rtl/fskm_cfg_regs.sv
// ----------------------------------------------------------------------------
// fskm_cfg_regs
// step registers written through the configuration channel
// ----------------------------------------------------------------------------
module fskm_cfg_regs import fskm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [StepBits-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMarkStep:  cfg_d.mark_step  = cfg_data_i;
        RegSpaceStep: cfg_d.space_step = cfg_data_i;
        RegBitStep:   cfg_d.bit_step   = cfg_data_i;
        default:      cfg_d = cfg_q;  // unmapped index is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mark_step: MarkStepRst, space_step: SpaceStepRst, bit_step: BitStepRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/fskm_engine.sv
// ----------------------------------------------------------------------------
// fskm_engine
// phase accumulator, bit timer, frame sequencer and sine table lookup
// ----------------------------------------------------------------------------
module fskm_engine import fskm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t res_o
);

  localparam sine_rom_t SineRom = build_sine_rom();

  logic [StepBits-1:0] phase_q, phase_d;
  logic [StepBits-1:0] timer_q, timer_d;
  logic [7:0]          shift_q, shift_d;
  logic                cur_q, cur_d;
  logic [LeftBits-1:0] left_q, left_d;
  logic                par_q, par_d;
  logic                idle_q, idle_d;

  logic [StepBits:0]   timer_sum;
  logic [LeftBits-1:0] left_dec;

  // result reflects state before this tick's update
  assign res_o.sample    = SineRom[phase_q[StepBits-1 -: AddrBits]];
  assign res_o.ready_res = idle_q;
  assign res_o.line_bit  = cur_q;

  assign timer_sum = {1'b0, timer_q} + {1'b0, cfg_i.bit_step};
  assign left_dec  = left_q - 4'd1;

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    shift_d = shift_q;
    cur_d   = cur_q;
    left_d  = left_q;
    par_d   = par_q;
    idle_d  = idle_q;
    if (go_i) begin
      if (word_i.cmd == CmdLoad) begin
        if (idle_q) begin
          shift_d = word_i.data_byte;
          par_d   = ^word_i.data_byte;
          cur_d   = 1'b0;                // start bit
          left_d  = FrameBits;
          timer_d = '0;
          idle_d  = 1'b0;
        end
      end else begin
        phase_d = phase_q + (cur_q ? cfg_i.mark_step : cfg_i.space_step);
        if (!idle_q) begin
          timer_d = timer_sum[StepBits-1:0];
          if (timer_sum[StepBits]) begin
            left_d = left_dec;
            if (left_dec == '0) begin
              idle_d = 1'b1;
              cur_d  = 1'b1;
            end else if (left_dec >= LeftData) begin
              cur_d   = shift_q[0];
              shift_d = {1'b0, shift_q[7:1]};
            end else if (left_dec == LeftParity) begin
              cur_d = par_q;
            end else begin
              cur_d = 1'b1;              // stop bit
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      timer_q <= '0;
      shift_q <= '0;
      cur_q   <= 1'b1;
      left_q  <= '0;
      par_q   <= 1'b0;
      idle_q  <= 1'b1;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      par_q   <= par_d;
      idle_q  <= idle_d;
    end
  end

  // idle exactly when no frame bits remain
  a_idle_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q == (left_q == '0))
    else $error("idle flag and bit count disagree");

  // line rests at mark while idle
  a_idle_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> cur_q)
    else $error("line not at mark while idle");

  // bit count never exceeds one frame
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= FrameBits)
    else $error("bit count out of range");

  // a load while idle starts a frame with the start bit
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && word_i.cmd == CmdLoad && idle_q) |=> (!idle_q && !cur_q && left_q == FrameBits))
    else $error("load did not start a frame");

endmodule

### rtl/fsk_uart_frame_modulator_core.sv
// ----------------------------------------------------------------------------
// fsk_uart_frame_modulator_core
// binary fsk modulator with uart framing feeding a 12-bit dac
// ----------------------------------------------------------------------------
// Takes one word per clock unless a tick waits on a stalled result. A tick
// word produces one result word carrying the sine table sample at the current
// phase, the ready flag and the line bit as they stood before the tick; a
// load word starts a frame (start bit, eight data bits lsb first, even
// parity, stop bit) when the block is idle, is dropped otherwise, and
// produces no result. Each accepted word passes an input register, then the
// accumulate and frame update logic with a 256-entry constant table read,
// then the result register. A new word is accepted every cycle as long as
// the result side keeps taking words. A stalled result holds the tick behind
// it in the input register; load words never wait on the result side. The
// step registers take a write every cycle.
// ----------------------------------------------------------------------------
module fsk_uart_frame_modulator_core import fskm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  // step register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [StepBits-1:0] cfg_data_i
);

  cfg_t      cfg;
  out_word_t res;

  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;

  logic      out_free;
  logic      s1_tick;
  logic      s1_go;

  fskm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result slot free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_tick  = s1_word_q.cmd == CmdTick;
  // loads advance regardless of the result side
  assign s1_go    = s1_valid_q && (!s1_tick || out_free);

  assign in_stall_o  = s1_valid_q && !s1_go;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  fskm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (s1_go),
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= in_word_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_tick) begin
      out_word_q <= res;
    end
  end

endmodule
